// ----- sv/vsab_pkg.sv -----
// ----------------------------------------------------------------------------
// vsab_pkg
// Shared widths, codes and types for the variable-step Adams-Bashforth block.
// ----------------------------------------------------------------------------
package vsab_pkg;

  localparam int VB      = 32;           // value / force width
  localparam int WB      = 40;           // weight width, 32 fraction bits
  localparam int FRAC    = 32;
  localparam int SB      = 32;           // step register width
  localparam int MB      = 36;           // coefficient multiplier B width
  localparam int MP      = 32 + MB;      // coefficient multiplier product width
  localparam int PW      = 100;          // numerator / denominator width
  localparam int DN      = PW + 1;       // dividend bits after rounding offset
  localparam int RW      = 69;           // divider remainder width
  localparam int PRODW   = WB + VB;
  localparam int ACC_W   = WB + VB + 2;
  localparam int QD      = 4;            // front-to-back queue depth
  localparam int OD      = 8;            // result queue depth
  localparam int CIW     = 8;            // config index width

  localparam logic [CIW-1:0] CFG_STEP_NOW   = CIW'(0);
  localparam logic [CIW-1:0] CFG_STEP_PREV  = CIW'(1);
  localparam logic [CIW-1:0] CFG_STEP_PREV2 = CIW'(2);
  localparam logic [CIW-1:0] CFG_ORDER      = CIW'(3);

  localparam logic [1:0] ORDER_AB2 = 2'd2;
  localparam logic [1:0] ORDER_AB3 = 2'd3;

  localparam logic [SB-1:0] STEP_RESET = SB'(42949673);
  localparam logic [1:0]    ORDER_RESET = 2'd1;

  localparam logic [WB-1:0] WCAP = {1'b0, {(WB-1){1'b1}}};

  typedef enum logic [2:0] {
    C_IDLE, C_SQR, C_NLO, C_NHI, C_DLO, C_DHI, C_PREP, C_DIV
  } coef_state_t;

  typedef struct packed {
    logic [VB-1:0] value_re;
    logic [VB-1:0] value_im;
    logic [VB-1:0] force_new_re;
    logic [VB-1:0] force_new_im;
    logic [VB-1:0] force_mid_re;
    logic [VB-1:0] force_mid_im;
    logic [VB-1:0] force_old_re;
    logic [VB-1:0] force_old_im;
  } item_t;

  typedef struct packed {
    logic          ready;
    logic [WB-1:0] w_new;
    logic [WB-1:0] w_mid;
    logic [WB-1:0] w_old;
    logic          fault;
  } weights_t;

  typedef struct packed {
    logic [VB-1:0] updated_re;
    logic [VB-1:0] updated_im;
    logic          saturated;
    logic          coef_fault;
  } result_t;

endpackage

// ----- sv/vsab_front.sv -----
// ----------------------------------------------------------------------------
// vsab_front
// Input queue: takes items from the feeder and holds them for the datapath.
// ----------------------------------------------------------------------------
module vsab_front
  import vsab_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t item_in,
  output logic  avail,
  output item_t item_out,
  input  logic  deq
);

  localparam int AW = $clog2(QD);
  localparam int CW = $clog2(QD + 1);

  item_t          mem [QD];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full     = (count == CW'(QD));
  assign avail    = (count != '0);
  assign item_out = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = deq && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + AW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/vsab_coef.sv -----
// ----------------------------------------------------------------------------
// vsab_coef
// Step/order registers and the weight sequencer: one shared 32x36 multiplier
// and a restoring divider retiring one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vsab_coef
  import vsab_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [CIW-1:0] cfg_index,
  input  logic [31:0]    cfg_data,
  output weights_t       wts
);

  logic [SB-1:0] step_now, step_prev, step_prev2;
  logic [1:0]    order;
  logic          stale;

  coef_state_t state, state_next;
  logic [1:0]    term;
  logic [63:0]   hh;
  logic [PW-1:0] num, den;
  logic [MP-1:0] part;
  logic [DN-1:0] dvd;
  logic [RW-1:0] rem;
  logic [WB-1:0] quo;
  logic          sticky;
  logic [6:0]    cnt;
  logic [WB-1:0] w_new, w_mid, w_old;
  logic          fault;

  logic [31:0]   mul_a;
  logic [MB-1:0] mul_b;
  logic [MP-1:0] mul_p;
  logic [MB-1:0] nb, db;
  logic [63:0]   da;
  logic [RW-1:0] r2;
  logic          fit;
  logic [WB-1:0] quo_n;
  logic          sticky_n;
  logic          over;
  logic [WB-1:0] qc;
  logic [WB:0]   hsum;
  logic [WB-1:0] hcap;
  logic          ab2, ab3, bad;
  logic          cfg_hit;

  assign ab2 = (order == ORDER_AB2);
  assign ab3 = (order == ORDER_AB3);
  assign bad = (ab2 && step_prev == '0) ||
               (ab3 && (step_prev == '0 || step_prev2 == '0));
  assign cfg_hit = cfg_we && (cfg_index <= CFG_ORDER);

  // Per-term operands: numerator is hh * nb, denominator da * db
  always_comb begin
    nb = MB'(1);
    da = 64'(step_prev) << 1;
    db = MB'(1);
    if (ab3) begin
      case (term)
        2'd0: begin
          nb = (MB'(step_now) << 1) + MB'(step_prev) * MB'(6) + MB'(step_prev2) * MB'(3);
          da = 64'(step_prev) * 64'(6);
          db = MB'(step_prev) + MB'(step_prev2);
        end
        2'd1: begin
          nb = (MB'(step_now) << 1) + MB'(step_prev) * MB'(3) + MB'(step_prev2) * MB'(3);
          da = 64'(step_prev) * 64'(6);
          db = MB'(step_prev2);
        end
        default: begin
          nb = (MB'(step_now) << 1) + MB'(step_prev) * MB'(3);
          da = (64'(step_prev) + 64'(step_prev2)) * 64'(6);
          db = MB'(step_prev2);
        end
      endcase
    end
  end

  always_comb begin
    mul_a = step_now;
    mul_b = MB'(step_now);
    case (state)
      C_NLO:   begin mul_a = hh[31:0];  mul_b = nb; end
      C_NHI:   begin mul_a = hh[63:32]; mul_b = nb; end
      C_DLO:   begin mul_a = da[31:0];  mul_b = db; end
      C_DHI:   begin mul_a = da[63:32]; mul_b = db; end
      default: begin mul_a = step_now;  mul_b = MB'(step_now); end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // quotient after this cycle's bit; the last bit lands as the weight is taken
  assign r2       = {rem[RW-2:0], dvd[DN-1]};
  assign fit      = ({1'b0, r2} >= (RW+1)'(den));
  assign quo_n    = {quo[WB-2:0], fit};
  assign sticky_n = sticky | quo[WB-1];
  assign over     = sticky_n || quo_n[WB-1];
  assign qc       = over ? WCAP : quo_n;
  assign hsum     = (WB+1)'(step_now) + (WB+1)'(qc);
  assign hcap     = (hsum > (WB+1)'(WCAP)) ? WCAP : hsum[WB-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      C_IDLE: if (stale && !bad && (ab2 || ab3)) state_next = C_SQR;
      C_SQR:  state_next = C_NLO;
      C_NLO:  state_next = C_NHI;
      C_NHI:  state_next = C_DLO;
      C_DLO:  state_next = C_DHI;
      C_DHI:  state_next = C_PREP;
      C_PREP: state_next = C_DIV;
      C_DIV: begin
        if (cnt == '0) begin
          if (ab3 && term != 2'd2) state_next = C_NLO;
          else                     state_next = C_IDLE;
        end
      end
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= C_IDLE;
      stale      <= 1'b1;
      step_now   <= STEP_RESET;
      step_prev  <= STEP_RESET;
      step_prev2 <= STEP_RESET;
      order      <= ORDER_RESET;
      term       <= '0;
      w_new      <= '0;
      w_mid      <= '0;
      w_old      <= '0;
      fault      <= 1'b0;
    end else begin
      state <= state_next;
      // a write during a derivation forces a fresh one when it ends
      if (cfg_hit) begin
        stale <= 1'b1;
      end else if (state == C_IDLE && stale) begin
        stale <= 1'b0;
      end
      if (state == C_IDLE && stale) begin
        term  <= '0;
        w_mid <= '0;
        w_old <= '0;
        fault <= bad;
        if (bad)             w_new <= '0;
        else if (!(ab2 || ab3)) w_new <= (WB'(step_now) > WCAP) ? WCAP : WB'(step_now);
      end
      if (state == C_DIV && cnt == '0) begin
        term <= term + 2'd1;
        case (term)
          2'd0: begin
            w_new <= hcap;
            if (ab2) w_mid <= WB'(0) - qc;
          end
          2'd1:    w_mid <= WB'(0) - qc;
          default: w_old <= qc;
        endcase
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_NOW:   step_now   <= cfg_data;
          CFG_STEP_PREV:  step_prev  <= cfg_data;
          CFG_STEP_PREV2: step_prev2 <= cfg_data;
          CFG_ORDER:      order      <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      C_SQR: hh <= mul_p[63:0];
      C_NLO: part <= mul_p;
      C_NHI: num <= (PW'(mul_p) << 32) + PW'(part);
      C_DLO: part <= mul_p;
      C_DHI: den <= (PW'(mul_p) << 32) + PW'(part);
      C_PREP: begin
        dvd    <= DN'(num) + DN'(den >> 1);
        rem    <= '0;
        quo    <= '0;
        sticky <= 1'b0;
        cnt    <= 7'(DN - 1);
      end
      C_DIV: begin
        dvd    <= dvd << 1;
        rem    <= fit ? RW'(r2 - RW'(den)) : r2;
        quo    <= quo_n;
        sticky <= sticky_n;
        cnt    <= cnt - 7'd1;
      end
      default: ;
    endcase
  end

  assign wts.ready = (state == C_IDLE) && !stale;
  assign wts.w_new = w_new;
  assign wts.w_mid = w_mid;
  assign wts.w_old = w_old;
  assign wts.fault = fault;

endmodule

// ----- sv/vsab_back.sv -----
// ----------------------------------------------------------------------------
// vsab_back
// Update datapath: products, sum with rounding, saturation, result queue.
// ----------------------------------------------------------------------------
module vsab_back
  import vsab_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  weights_t wts,
  input  logic     avail,
  input  item_t    item,
  output logic     deq,
  output logic     empty,
  input  logic     pop,
  output result_t  res
);

  localparam int AW = $clog2(OD);
  localparam int CW = $clog2(OD + 1);
  localparam logic signed [ACC_W-1:0] VMAX = ACC_W'({1'b0, {(VB-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] VMIN = -VMAX - ACC_W'(1);

  logic                     v1, v2;
  logic signed [PRODW-1:0]  p [6];
  logic signed [VB-1:0]     val1 [2];
  logic                     flt1, flt2;
  logic signed [ACC_W-1:0]  acc [2];
  logic signed [ACC_W-1:0]  sh  [2];
  logic [VB-1:0]            outv [2];
  logic [1:0]               clip;

  result_t        mem [OD];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic [CW+1:0]  used;
  logic           do_pop;

  assign used   = (CW+2)'(count) + (CW+2)'(v1) + (CW+2)'(v2);
  assign deq    = avail && wts.ready && (used < (CW+2)'(OD));
  assign empty  = (count == '0);
  assign res    = mem[rd_ptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (deq) begin
      p[0] <= $signed(wts.w_new) * $signed(item.force_new_re);
      p[1] <= $signed(wts.w_mid) * $signed(item.force_mid_re);
      p[2] <= $signed(wts.w_old) * $signed(item.force_old_re);
      p[3] <= $signed(wts.w_new) * $signed(item.force_new_im);
      p[4] <= $signed(wts.w_mid) * $signed(item.force_mid_im);
      p[5] <= $signed(wts.w_old) * $signed(item.force_old_im);
      val1[0] <= item.value_re;
      val1[1] <= item.value_im;
      flt1    <= wts.fault;
    end
    if (v1) begin
      for (int k = 0; k < 2; k++) begin
        acc[k] <= (ACC_W'(val1[k]) <<< FRAC) + ACC_W'(p[3*k]) + ACC_W'(p[3*k+1])
                  + ACC_W'(p[3*k+2]) + (ACC_W'(1) <<< (FRAC - 1));
      end
      flt2 <= flt1;
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      sh[k] = acc[k] >>> FRAC;
      clip[k] = 1'b0;
      if (sh[k] > VMAX) begin
        outv[k] = VMAX[VB-1:0];
        clip[k] = 1'b1;
      end else if (sh[k] < VMIN) begin
        outv[k] = VMIN[VB-1:0];
        clip[k] = 1'b1;
      end else begin
        outv[k] = sh[k][VB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      mem[wr_ptr] <= '{updated_re: outv[0], updated_im: outv[1],
                       saturated: |clip, coef_fault: flt2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      v1 <= deq;
      v2 <= v1;
      if (v2)     wr_ptr <= wr_ptr + AW'(1);
      if (do_pop) rd_ptr <= rd_ptr + AW'(1);
      case ({v2, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/variable_step_adams_bashforth.sv -----
// ----------------------------------------------------------------------------
// variable_step_adams_bashforth
// Variable-step AB1/AB2/AB3 update of a stream of complex Q16.16 values.
// ----------------------------------------------------------------------------
//   channel  | handshake              | payload
//   input    | push / full            | value, three forces (re, im)
//   result   | pop / empty            | updated_re/im, saturated, coef_fault
//   config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per cycle sustained while the weights are ready and the result
// queue has room; a result passes the input queue, the product and sum
// registers and the result queue. After reset and after each step or order
// register write the weight sequencer runs, one term for AB2 and three for
// AB3, each with its products and a division; items queue meanwhile.
// A 4-deep input queue and an 8-deep result queue let either side stall.
// Synchronous active-high reset clears control state and reloads registers.
// ----------------------------------------------------------------------------
module variable_step_adams_bashforth
  import vsab_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [VB-1:0]  value_re,
  input  logic [VB-1:0]  value_im,
  input  logic [VB-1:0]  force_new_re,
  input  logic [VB-1:0]  force_new_im,
  input  logic [VB-1:0]  force_mid_re,
  input  logic [VB-1:0]  force_mid_im,
  input  logic [VB-1:0]  force_old_re,
  input  logic [VB-1:0]  force_old_im,
  output logic           empty,
  input  logic           pop,
  output logic [VB-1:0]  updated_re,
  output logic [VB-1:0]  updated_im,
  output logic           saturated,
  output logic           coef_fault,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [CIW-1:0] cfg_index,
  input  logic [31:0]    cfg_data
);

  item_t    item_in, item_q;
  logic     avail, deq;
  weights_t wts;
  result_t  res;

  assign item_in = '{value_re: value_re, value_im: value_im,
                     force_new_re: force_new_re, force_new_im: force_new_im,
                     force_mid_re: force_mid_re, force_mid_im: force_mid_im,
                     force_old_re: force_old_re, force_old_im: force_old_im};

  assign cfg_ready = 1'b1;

  vsab_front u_front (
    .clk, .rst, .push, .full,
    .item_in, .avail, .item_out(item_q), .deq
  );

  vsab_coef u_coef (
    .clk, .rst,
    .cfg_we(cfg_valid && cfg_ready), .cfg_index, .cfg_data, .wts
  );

  vsab_back u_back (
    .clk, .rst, .wts, .avail, .item(item_q), .deq,
    .empty, .pop, .res
  );

  assign updated_re = res.updated_re;
  assign updated_im = res.updated_im;
  assign saturated  = res.saturated;
  assign coef_fault = res.coef_fault;

endmodule
